// ===== rtl/lgrs_pkg.sv =====
package lgrs_pkg;

    localparam int ROW_BITS   = 64;
    localparam int WIDTH_BITS = 7;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = 2;
    localparam int CNT_BITS   = 3;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // one column's bits as seen by its neighbors, already masked to the grid
    typedef struct packed {
        logic above;
        logic mid;
        logic cur;
    } t_col;

    typedef struct packed {
        logic [ROW_BITS-1:0] cells;
        logic                eog;
    } t_res;

    function automatic logic life_rule(input logic [3:0] n, input logic alive);
        return (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && alive);
    endfunction

endpackage

// ===== rtl/life_generation_row_stencil_top.sv =====
// channel   direction  handshake                  payload
// row       in         i_row_valid / o_row_stall  i_row_cells, i_last_row
// result    out        o_res_valid / i_res_stall  o_next_cells, o_end_of_grid
// config    in         i_cfg_we                   i_cfg_wdata (grid width)
//
// one row is taken every cycle unless o_row_stall is high; the column cells form the stencil
// combinationally and results are registered in a four-entry queue.
// the row side stalls while the queue has fewer than two free entries.
// synchronous active-low reset empties the queue, clears held rows, width 64.
module life_generation_row_stencil_top
    import lgrs_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_row_valid,
    output logic                  o_row_stall,
    input  logic [ROW_BITS-1:0]   i_row_cells,
    input  logic                  i_last_row,
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    output logic [ROW_BITS-1:0]   o_next_cells,
    output logic                  o_end_of_grid,
    input  logic                  i_cfg_we,
    input  logic [WIDTH_BITS-1:0] i_cfg_wdata
);

    localparam logic [WIDTH_BITS-1:0] MAX_W = WIDTH_BITS'(MAX_WIDTH);

    logic [WIDTH_BITS-1:0] r_width;
    logic                  r_held;
    logic [WIDTH_BITS-1:0] w_eff;
    logic                  w_acc;
    logic [ROW_BITS-1:0]   w_next_a;
    logic [ROW_BITS-1:0]   w_next_b;
    t_col                  w_col [MAX_WIDTH];
    logic [1:0]            w_n_push;
    t_res                  w_wr0;
    t_res                  w_wr1;
    t_res                  w_rd;
    logic                  w_no_room;

    assign w_eff = (r_width > MAX_W) ? MAX_W : r_width;
    assign o_row_stall = w_no_room;
    assign w_acc = i_row_valid & ~w_no_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_BITS'(64);
            r_held  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
            if (w_acc) begin
                r_held <= ~i_last_row;
            end
        end
    end

    for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_col
        t_col w_left;
        t_col w_right;
        logic w_en;

        assign w_en = (WIDTH_BITS'(k) < w_eff);
        if (k == 0) begin : g_l0
            assign w_left = '0;
        end else begin : g_l
            assign w_left = w_col[k-1];
        end
        if (k == MAX_WIDTH - 1) begin : g_r0
            assign w_right = '0;
        end else begin : g_r
            assign w_right = w_col[k+1];
        end

        lgrs_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_load   (w_acc),
            .i_last   (i_last_row),
            .i_cur    (i_row_cells[k]),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_col    (w_col[k]),
            .o_next_a (w_next_a[k]),
            .o_next_b (w_next_b[k])
        );
    end

    if (MAX_WIDTH < ROW_BITS) begin : g_pad
        assign w_next_a[ROW_BITS-1:MAX_WIDTH] = '0;
        assign w_next_b[ROW_BITS-1:MAX_WIDTH] = '0;
    end

    // held row first, then the flushed last row
    always_comb begin
        w_n_push = 2'(w_acc & r_held) + 2'(w_acc & i_last_row);
        w_wr1.cells = w_next_b;
        w_wr1.eog   = 1'b1;
        if (r_held) begin
            w_wr0.cells = w_next_a;
            w_wr0.eog   = 1'b0;
        end else begin
            w_wr0 = w_wr1;
        end
    end

    lgrs_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_n_push  (w_n_push),
        .i_wr0     (w_wr0),
        .i_wr1     (w_wr1),
        .i_pop     (~i_res_stall),
        .o_valid   (o_res_valid),
        .o_rd      (w_rd),
        .o_no_room (w_no_room)
    );

    assign o_next_cells  = w_rd.cells;
    assign o_end_of_grid = w_rd.eog;

endmodule

// ===== rtl/lgrs_cell.sv =====
module lgrs_cell
    import lgrs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_load,
    input  logic i_last,
    input  logic i_cur,
    input  t_col i_left,
    input  t_col i_right,
    output t_col o_col,
    output logic o_next_a,
    output logic o_next_b
);

    logic r_above;
    logic r_mid;
    logic w_cur;
    logic [3:0] w_n_a;
    logic [3:0] w_n_b;

    assign w_cur = i_cur & i_en;

    // held rows may carry bits beyond a narrowed width, so mask on the way out
    assign o_col.above = r_above & i_en;
    assign o_col.mid   = r_mid & i_en;
    assign o_col.cur   = w_cur;

    // result for the held middle row, incoming row below it
    assign w_n_a = 4'(i_left.above) + 4'(o_col.above) + 4'(i_right.above)
                 + 4'(i_left.mid) + 4'(i_right.mid)
                 + 4'(i_left.cur) + 4'(o_col.cur) + 4'(i_right.cur);

    // result for the incoming row with a dead row below
    assign w_n_b = 4'(i_left.mid) + 4'(o_col.mid) + 4'(i_right.mid)
                 + 4'(i_left.cur) + 4'(i_right.cur);

    assign o_next_a = i_en & life_rule(w_n_a, o_col.mid);
    assign o_next_b = i_en & life_rule(w_n_b, o_col.cur);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above <= 1'b0;
            r_mid   <= 1'b0;
        end else if (i_load) begin
            if (i_last) begin
                r_above <= 1'b0;
                r_mid   <= 1'b0;
            end else begin
                r_above <= r_mid;
                r_mid   <= w_cur;
            end
        end
    end

endmodule

// ===== rtl/lgrs_fifo.sv =====
module lgrs_fifo
    import lgrs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [1:0]   i_n_push,
    input  t_res         i_wr0,
    input  t_res         i_wr1,
    input  logic         i_pop,
    output logic         o_valid,
    output t_res         o_rd,
    output logic         o_no_room
);

    t_res                mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] w_wr_ptr1;
    logic                w_pop;

    assign w_wr_ptr1 = r_wr_ptr + PTR_BITS'(1);
    assign o_valid   = (r_count != '0);
    assign w_pop     = i_pop & o_valid;
    assign o_rd      = mem[r_rd_ptr];
    // one request may bring two results
    assign o_no_room = (r_count > CNT_BITS'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_BITS'(i_n_push);
            r_rd_ptr <= r_rd_ptr + PTR_BITS'(w_pop);
            r_count  <= r_count + CNT_BITS'(i_n_push) - CNT_BITS'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_n_push != 2'd0) begin
            mem[r_wr_ptr] <= i_wr0;
        end
        if (i_n_push == 2'd2) begin
            mem[w_wr_ptr1] <= i_wr1;
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import lgrs_pkg::*;
();

    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 10;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 182;
    localparam int NUM_PHASES     = 4;
    localparam int NUM_DIR_ROWS   = 23;

    localparam logic [ROW_BITS-1:0] ALL_LIVE = {ROW_BITS{1'b1}};

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_row_valid   = 1'b0;
    logic                  o_row_stall;
    logic [ROW_BITS-1:0]   i_row_cells   = '0;
    logic                  i_last_row    = 1'b0;
    logic                  o_res_valid;
    logic                  i_res_stall   = 1'b0;
    logic [ROW_BITS-1:0]   o_next_cells;
    logic                  o_end_of_grid;
    logic                  i_cfg_we      = 1'b0;
    logic [WIDTH_BITS-1:0] i_cfg_wdata   = '0;

    life_generation_row_stencil_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_row_valid   (i_row_valid),
        .o_row_stall   (o_row_stall),
        .i_row_cells   (i_row_cells),
        .i_last_row    (i_last_row),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_next_cells  (o_next_cells),
        .o_end_of_grid (o_end_of_grid),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block: width register and the two held rows
    logic [WIDTH_BITS-1:0] width_reg   = 7'd64;
    logic [ROW_BITS-1:0]   up_row      = '0;
    logic [ROW_BITS-1:0]   mid_row     = '0;
    bit                    row_pending = 1'b0;
    t_res                  next_rows_q[$];

    int errors         = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_asks      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    int phase_send_idle [NUM_PHASES] = '{0, 45, 0, 14};
    int phase_stall     [NUM_PHASES] = '{0, 0, 45, 14};
    logic [WIDTH_BITS-1:0] phase_width [NUM_PHASES] = '{7'd64, 7'd37, 7'd127, 7'd9};

    typedef struct packed {
        logic                  wr;
        logic [WIDTH_BITS-1:0] w;
        logic [ROW_BITS-1:0]   cells;
        logic                  last;
        logic                  typed;
        logic [ROW_BITS-1:0]   want;
    } t_dir_row;

    t_dir_row dir_rows [NUM_DIR_ROWS] = '{
        '{1'b0, 7'd0,   64'h0,                  1'b1, 1'b1, 64'h0},
        '{1'b0, 7'd0,   ALL_LIVE,               1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
        // vertical blinker
        '{1'b0, 7'd0,   64'h0,                  1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h2,                  1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h2,                  1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h2,                  1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h0,                  1'b1, 1'b0, 64'h0},
        '{1'b0, 7'd0,   ALL_LIVE,               1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   ALL_LIVE,               1'b1, 1'b0, 64'h0},
        // edge columns
        '{1'b0, 7'd0,   64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'hC000_0000_0000_0003, 1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0},
        '{1'b1, 7'd1,   ALL_LIVE,               1'b1, 1'b1, 64'h0},
        '{1'b1, 7'd0,   ALL_LIVE,               1'b1, 1'b1, 64'h0},
        // width above range clamps to the full row
        '{1'b1, 7'd127, ALL_LIVE,               1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
        '{1'b1, 7'd3,   ALL_LIVE,               1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h5,                  1'b0, 1'b0, 64'h0},
        // width changes while a row is held
        '{1'b1, 7'd40,  ALL_LIVE,               1'b1, 1'b0, 64'h0},
        '{1'b1, 7'd2,   ALL_LIVE,               1'b1, 1'b1, 64'h0},
        '{1'b1, 7'd63,  ALL_LIVE,               1'b1, 1'b1, 64'h3FFF_FFFF_FFFF_FFFE},
        '{1'b1, 7'd64,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0},
        '{1'b0, 7'd0,   64'hA5A5_0F0F_3C3C_FF00, 1'b1, 1'b0, 64'h0}
    };

    function automatic int eff_width(input logic [WIDTH_BITS-1:0] w);
        return (w > 7'd64) ? 64 : int'(w);
    endfunction

    function automatic logic [ROW_BITS-1:0] width_mask(input int w);
        return (w >= 64) ? ALL_LIVE : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic int live_at(input logic [ROW_BITS-1:0] row, input int col, input int w);
        if (col < 0 || col >= w)
            return 0;
        return int'(row[col]);
    endfunction

    function automatic logic [ROW_BITS-1:0] life_next(input logic [ROW_BITS-1:0] up,
                                                      input logic [ROW_BITS-1:0] mid,
                                                      input logic [ROW_BITS-1:0] dn,
                                                      input int w);
        logic [ROW_BITS-1:0] res;
        int                  n;
        res = '0;
        for (int k = 0; k < w; k++) begin
            n = 0;
            for (int d = -1; d <= 1; d++) begin
                n += live_at(up, k + d, w) + live_at(dn, k + d, w);
                if (d != 0)
                    n += live_at(mid, k + d, w);
            end
            if (n == 3 || (n == 2 && live_at(mid, k, w) == 1))
                res[k] = 1'b1;
        end
        return res & width_mask(w);
    endfunction

    // advance the shadow rows by one request and queue the rows it yields
    task automatic step_generation(input logic [ROW_BITS-1:0] cells, input logic last,
                                   input bit keep);
        logic [ROW_BITS-1:0] cur;
        t_res                r;
        int                  w;
        w   = eff_width(width_reg);
        cur = cells & width_mask(w);
        if (!row_pending) begin
            up_row  = '0;
            mid_row = cur;
        end else begin
            r.cells = life_next(up_row, mid_row, cur, w);
            r.eog   = 1'b0;
            if (keep)
                next_rows_q.push_back(r);
            up_row  = mid_row;
            mid_row = cur;
        end
        row_pending = 1'b1;
        if (last) begin
            r.cells = life_next(up_row, mid_row, '0, w);
            r.eog   = 1'b1;
            if (keep)
                next_rows_q.push_back(r);
            up_row      = '0;
            mid_row     = '0;
            row_pending = 1'b0;
        end
    endtask

    task automatic offer_row(input logic [ROW_BITS-1:0] cells, input logic last, input bit keep);
        while ($urandom_range(99) < send_idle_pct) begin
            i_row_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_row_valid <= 1'b1;
        i_row_cells <= cells;
        i_last_row  <= last;
        @(posedge i_clk);
        while (o_row_stall)
            @(posedge i_clk);
        step_generation(cells, last, keep);
    endtask

    task automatic wait_idle();
        i_row_valid <= 1'b0;
        @(posedge i_clk);
        while (next_rows_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [WIDTH_BITS-1:0] w);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        width_reg = w;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [ROW_BITS-1:0] rand_row();
        logic [ROW_BITS-1:0] a;
        logic [ROW_BITS-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALL_LIVE;
            2, 3:    return a & b;
            4:       return a | b;
            default: return a;
        endcase
    endfunction

    function automatic logic [WIDTH_BITS-1:0] pick_width();
        case ($urandom_range(7))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'd127;
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    // result side: random stall, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_res_stall <= 1'b1;
        end else begin
            i_res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (next_rows_q.size() == 0) begin
                $error("unexpected result: next_cells %h end_of_grid %b",
                       o_next_cells, o_end_of_grid);
                errors++;
            end else begin
                want = next_rows_q.pop_front();
                if (o_next_cells !== want.cells) begin
                    $error("next_cells expected %h actual %h", want.cells, o_next_cells);
                    errors++;
                end
                if (o_end_of_grid !== want.eog) begin
                    $error("end_of_grid expected %b actual %b", want.eog, o_end_of_grid);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_row_valid && !o_row_stall) || (o_res_valid && !i_res_stall)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int  rows;
        int  sent;
        bit  held;
        t_res r;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIR_ROWS; i++) begin
            if (dir_rows[i].wr)
                set_width(dir_rows[i].w);
            offer_row(dir_rows[i].cells, dir_rows[i].last, !dir_rows[i].typed);
            if (dir_rows[i].typed) begin
                r.cells = dir_rows[i].want;
                r.eog   = 1'b1;
                next_rows_q.push_back(r);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            // sender waits here for every owed row before the phase changes
            set_width(phase_width[p]);
            send_idle_pct = phase_send_idle[p];
            stall_pct     = phase_stall[p];
            sent = 0;
            held = 1'b0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(15) == 0)
                    set_width(pick_width());
                if ((p == 0 || p == 3) && !held && sent >= 50) begin
                    hold_asks++;
                    held = 1'b1;
                end
                rows = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
                for (int k = 0; k < rows; k++) begin
                    offer_row(rand_row(), k == rows - 1, 1'b1);
                    sent++;
                end
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && next_rows_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== life_generation_row_stencil_top.f =====
rtl/lgrs_pkg.sv
rtl/lgrs_cell.sv
rtl/lgrs_fifo.sv
rtl/life_generation_row_stencil_top.sv
verif/testbench.sv
